>>> src/tcpq_pkg.sv
// Package for the two-class priority queue: request and response types,
// action and status codes, cell control type and default sizes.
// Used by every module of the block; depends on nothing.
package tcpq_pkg;

  localparam int CLASS_DEPTH_DEF = 32;
  localparam int ID_W            = 16;
  localparam int CNT_OUT_W       = 7;

  // Action codes of a request.
  localparam logic [1:0] ACT_NORMAL   = 2'd0;
  localparam logic [1:0] ACT_PRIORITY = 2'd1;
  localparam logic [1:0] ACT_DEQUEUE  = 2'd2;

  // Status codes of a response.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] customer_id;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] ahead_count;
    logic [ID_W-1:0]      removed_id;
    logic                 removed_priority;
    logic [CNT_OUT_W-1:0] remaining;
  } out_rsp_t;

  // Per-cell control: shift towards the head, or load the new identifier.
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

>>> src/two_class_priority_queue_core.sv
// Top level of the two-class strict-priority queue of customer identifiers.
// Depends on tcpq_pkg and tcpq_chain (which uses tcpq_cell).
//
// The queue holds up to CLASS_DEPTH priority and CLASS_DEPTH normal identifiers,
// each class in its own chain of cells whose head sits in the first cell, so a
// dequeue reads a fixed place and every cell moves one step towards the head in
// the same cycle. A normal enqueue joins the back and reports every held entry
// as ahead of it; a priority enqueue goes behind the waiting priority entries
// and reports only those. A dequeue serves priority entries first. An enqueue
// into a full class, a dequeue on an empty queue and the unused action code
// change nothing; the first two say so in the status field. An accepted request
// updates the queue at the accepting edge, and its response is registered at
// that edge. One request per cycle is taken as long as responses are taken.
// A skid register holds one further response while the output is stalled;
// in_stall rises only while that skid register is full, and in_stall depends
// on no input combinationally.
module two_class_priority_queue_core #(
  parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tcpq_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output tcpq_pkg::out_rsp_t out_rsp
);
  import tcpq_pkg::*;

  localparam int CW = $clog2(CLASS_DEPTH + 1);  // per-class count width
  localparam int SW = CW + 1;                   // width of a total over both classes
  localparam int EW = SW + CNT_OUT_W;           // room to zero-extend before truncation

  // Handshake and request decode.
  logic acc;
  logic is_norm;
  logic is_pri;
  logic is_deq;

  // Class chains.
  logic [CW-1:0]   pri_cnt;
  logic [CW-1:0]   nrm_cnt;
  logic [ID_W-1:0] pri_head;
  logic [ID_W-1:0] nrm_head;
  logic            pri_full;
  logic            nrm_full;

  // Which update this request makes if accepted.
  logic ok_push_n;
  logic ok_push_p;
  logic ok_pop_p;
  logic ok_pop_n;

  logic [SW-1:0] total;
  logic [SW-1:0] total_after;
  logic [SW-1:0] ahead;
  logic [EW-1:0] ahead_ext;
  logic [EW-1:0] remain_ext;
  out_rsp_t      rsp;

  // Output register and skid register.
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_rsp_t out_rsp_r;
  out_rsp_t out_rsp_nxt;
  logic     skid_valid_r;
  logic     skid_valid_nxt;
  out_rsp_t skid_rsp_r;
  out_rsp_t skid_rsp_nxt;

  assign in_stall = skid_valid_r;
  assign acc      = in_valid && !skid_valid_r;

  assign is_norm = (in_req.action == ACT_NORMAL);
  assign is_pri  = (in_req.action == ACT_PRIORITY);
  assign is_deq  = (in_req.action == ACT_DEQUEUE);

  assign pri_full = (pri_cnt == CW'(CLASS_DEPTH));
  assign nrm_full = (nrm_cnt == CW'(CLASS_DEPTH));

  assign ok_push_n = is_norm && !nrm_full;
  assign ok_push_p = is_pri && !pri_full;
  assign ok_pop_p  = is_deq && (pri_cnt != '0);
  assign ok_pop_n  = is_deq && (pri_cnt == '0) && (nrm_cnt != '0);

  tcpq_chain #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .CW          (CW)
  ) u_pri_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (acc && ok_push_p),
    .pop     (acc && ok_pop_p),
    .push_id (in_req.customer_id),
    .head_id (pri_head),
    .count   (pri_cnt)
  );

  tcpq_chain #(
    .CLASS_DEPTH (CLASS_DEPTH),
    .CW          (CW)
  ) u_nrm_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (acc && ok_push_n),
    .pop     (acc && ok_pop_n),
    .push_id (in_req.customer_id),
    .head_id (nrm_head),
    .count   (nrm_cnt)
  );

  // Response for the request at the input, built from the state it sees.
  always_comb begin
    total       = SW'(pri_cnt) + SW'(nrm_cnt);
    total_after = total;
    ahead       = '0;
    if (ok_push_n) begin
      ahead       = total;
      total_after = total + SW'(1);
    end else if (ok_push_p) begin
      ahead       = SW'(pri_cnt);
      total_after = total + SW'(1);
    end else if (ok_pop_p || ok_pop_n) begin
      total_after = total - SW'(1);
    end
    ahead_ext  = EW'(ahead);
    remain_ext = EW'(total_after);

    rsp                  = '0;
    rsp.ahead_count      = ahead_ext[CNT_OUT_W-1:0];
    rsp.remaining        = remain_ext[CNT_OUT_W-1:0];
    rsp.removed_priority = ok_pop_p;
    if (ok_pop_p) begin
      rsp.removed_id = pri_head;
    end else if (ok_pop_n) begin
      rsp.removed_id = nrm_head;
    end
    if ((is_norm && nrm_full) || (is_pri && pri_full)) begin
      rsp.status = ST_FULL;
    end else if (is_deq && !ok_pop_p && !ok_pop_n) begin
      rsp.status = ST_EMPTY;
    end else begin
      rsp.status = ST_OK;
    end
  end

  // Output staging: the skid register only fills while the output register is
  // held, and it drains into the output register as soon as that is taken.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_rsp_nxt    = out_rsp_r;
    skid_valid_nxt = skid_valid_r;
    skid_rsp_nxt   = skid_rsp_r;
    if (!out_valid_r) begin
      out_valid_nxt = acc;
      out_rsp_nxt   = rsp;
    end else if (out_stall) begin
      if (acc) begin
        skid_valid_nxt = 1'b1;
        skid_rsp_nxt   = rsp;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_rsp_nxt    = skid_rsp_r;
      skid_valid_nxt = acc;
      skid_rsp_nxt   = rsp;
    end else begin
      out_valid_nxt = acc;
      out_rsp_nxt   = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r  <= out_rsp_nxt;
    skid_rsp_r <= skid_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The skid register never holds a response unless the output register does.
  a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  // Neither class ever holds more than its depth.
  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (pri_cnt <= CW'(CLASS_DEPTH)) && (nrm_cnt <= CW'(CLASS_DEPTH)))
    else $error("class count beyond depth");

  // A dequeue with priority entries waiting takes one of them, never a normal one.
  a_pri_first : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_deq && (pri_cnt != '0)) |=>
      ((pri_cnt == $past(pri_cnt) - CW'(1)) && (nrm_cnt == $past(nrm_cnt))))
    else $error("dequeue did not serve the priority class first");

endmodule

>>> src/tcpq_cell.sv
// One storage cell of a class chain: holds one identifier.
// Depends on tcpq_pkg.
module tcpq_cell (
  input  logic                   clk,
  input  tcpq_pkg::cell_ctrl_t   ctrl,
  input  logic [tcpq_pkg::ID_W-1:0] load_id,
  input  logic [tcpq_pkg::ID_W-1:0] nbr_id,
  output logic [tcpq_pkg::ID_W-1:0] id_o
);
  import tcpq_pkg::*;

  logic [ID_W-1:0] id_r;

  // Loading a new entry and shifting never coincide, as one request does one of them.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      id_r <= load_id;
    end else if (ctrl.shift) begin
      id_r <= nbr_id;
    end
  end

  assign id_o = id_r;

endmodule

>>> src/tcpq_chain.sv
// One class of the queue: a row of cells with the head in cell zero, and its fill count.
// Depends on tcpq_pkg and tcpq_cell.
module tcpq_chain #(
  parameter int CLASS_DEPTH = tcpq_pkg::CLASS_DEPTH_DEF,
  parameter int CW          = $clog2(CLASS_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic                      pop,
  input  logic [tcpq_pkg::ID_W-1:0] push_id,
  output logic [tcpq_pkg::ID_W-1:0] head_id,
  output logic [CW-1:0]             count
);
  import tcpq_pkg::*;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic [ID_W-1:0] cell_id [CLASS_DEPTH];
  cell_ctrl_t      ctrl    [CLASS_DEPTH];

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_r + CW'(1);
    end else if (pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  for (genvar i = 0; i < CLASS_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] nbr;

    // The new entry lands in the first free cell; a pop moves every cell one step on.
    assign ctrl[i].load  = push && (count_r == CW'(i));
    assign ctrl[i].shift = pop;

    if (i == CLASS_DEPTH - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_id[i+1];
    end

    tcpq_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl[i]),
      .load_id (push_id),
      .nbr_id  (nbr),
      .id_o    (cell_id[i])
    );
  end

  assign head_id = cell_id[0];
  assign count   = count_r;

endmodule

>>> bench/tb_two_class_priority_queue_core.sv
// Self-checking bench for two_class_priority_queue_core: a scripted opening and
// then randomised request traffic, every response checked against a queue model
// or a typed-in one. Depends on tcpq_pkg and the block RTL; needs no files or arguments.
module tb_two_class_priority_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tcpq_pkg::*;

  // The block keeps its default class depth; the model mirrors it.
  localparam int DEPTH         = CLASS_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 1250;
  localparam int TAIL_CYCLES   = 20;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int PRINT_LIMIT   = 100;
  localparam int IDLE_PERCENT  = 33;

  // The action code that the block decodes as "do nothing".
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam out_rsp_t NO_RSP = '0;

  // One row of the scripted opening. Where pinned is set, the response is typed
  // in by hand; otherwise the model supplies it.
  typedef struct packed {
    in_req_t  req;
    logic     pinned;
    out_rsp_t rsp;
  } script_row_t;

  // Traffic mixes for the random part. The two fill mixes push one class
  // towards its depth, the drain mix empties the queue and churn stirs both.
  typedef enum int {
    MIX_FILL_NORMAL,
    MIX_FILL_PRIORITY,
    MIX_DRAIN,
    MIX_CHURN
  } mix_t;

  localparam int SCRIPT_LEN = 21;

  // The opening walks the obvious corners: a dequeue right after reset, the unused
  // code, both identifier extremes as normal entries, the top one as a priority
  // entry, a priority request overtaking normal ones and the queue run dry repeatedly.
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b1, '{ST_EMPTY, 7'd0, 16'h0000, 1'b0, 7'd0}},
    '{'{ACT_UNUSED,   16'hFFFF}, 1'b1, '{ST_OK,    7'd0, 16'h0000, 1'b0, 7'd0}},
    '{'{ACT_NORMAL,   16'h0000}, 1'b1, '{ST_OK,    7'd0, 16'h0000, 1'b0, 7'd1}},
    '{'{ACT_NORMAL,   16'hFFFF}, 1'b1, '{ST_OK,    7'd1, 16'h0000, 1'b0, 7'd2}},
    '{'{ACT_PRIORITY, 16'h1234}, 1'b1, '{ST_OK,    7'd0, 16'h0000, 1'b0, 7'd3}},
    '{'{ACT_PRIORITY, 16'hAAAA}, 1'b1, '{ST_OK,    7'd1, 16'h0000, 1'b0, 7'd4}},
    '{'{ACT_NORMAL,   16'h5555}, 1'b0, NO_RSP},
    '{'{ACT_UNUSED,   16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'hFFFF}, 1'b0, NO_RSP},
    '{'{ACT_PRIORITY, 16'h8000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_NORMAL,   16'h0001}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b1, '{ST_EMPTY, 7'd0, 16'h0000, 1'b0, 7'd0}},
    '{'{ACT_PRIORITY, 16'hFFFF}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'h0000}, 1'b0, NO_RSP},
    '{'{ACT_DEQUEUE,  16'hFFFF}, 1'b1, '{ST_EMPTY, 7'd0, 16'h0000, 1'b0, 7'd0}}
  };

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_rsp;

  // While steady is set, neither side inserts idle cycles.
  logic steady = 1'b0;

  int fault_count = 0;

  // Model state: one list of waiting identifiers per class, oldest first.
  logic [ID_W-1:0] prio_ids[$];
  logic [ID_W-1:0] norm_ids[$];

  // Responses still owed by the block, oldest first.
  out_rsp_t awaited_rsp[$];

  two_class_priority_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Counts every mismatch; the printing is capped so that a badly broken
  // block cannot flood the log.
  task automatic flag_mismatch(input string msg);
    fault_count++;
    if (fault_count <= PRINT_LIMIT) begin
      $display("MISMATCH at %0d ns: %s", $time, msg);
    end
  endtask

  task automatic compare_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    end
  endtask

  // Applies one request to the model queue and returns the response that the
  // block owes for it. Priority entries are served before any normal entry;
  // a full class or an empty queue leaves everything as it was.
  function automatic out_rsp_t serve_request(input in_req_t req);
    out_rsp_t rsp;
    int       held;
    rsp = '0;
    case (req.action)
      ACT_NORMAL: begin
        if (norm_ids.size() >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.ahead_count = CNT_OUT_W'(prio_ids.size() + norm_ids.size());
          norm_ids.push_back(req.customer_id);
        end
      end
      ACT_PRIORITY: begin
        if (prio_ids.size() >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          rsp.ahead_count = CNT_OUT_W'(prio_ids.size());
          prio_ids.push_back(req.customer_id);
        end
      end
      ACT_DEQUEUE: begin
        if (prio_ids.size() != 0) begin
          rsp.removed_id       = prio_ids.pop_front();
          rsp.removed_priority = 1'b1;
        end else if (norm_ids.size() != 0) begin
          rsp.removed_id = norm_ids.pop_front();
        end else begin
          rsp.status = ST_EMPTY;
        end
      end
      default: begin
        // The unused code only reports the current total.
      end
    endcase
    held          = prio_ids.size() + norm_ids.size();
    rsp.remaining = CNT_OUT_W'(held);
    return rsp;
  endfunction

  // Draws one random request for the given mix. A few percent carry the
  // unused action code, and now and then the identifier sits at an extreme.
  function automatic in_req_t pick_req(input mix_t mix);
    in_req_t req;
    int      roll;
    roll            = $urandom_range(99);
    req.customer_id = ID_W'($urandom);
    case (mix)
      MIX_FILL_NORMAL:
        req.action = (roll < 65) ? ACT_NORMAL : (roll < 80) ? ACT_PRIORITY :
                     (roll < 96) ? ACT_DEQUEUE : ACT_UNUSED;
      MIX_FILL_PRIORITY:
        req.action = (roll < 65) ? ACT_PRIORITY : (roll < 80) ? ACT_NORMAL :
                     (roll < 96) ? ACT_DEQUEUE : ACT_UNUSED;
      MIX_DRAIN:
        req.action = (roll < 70) ? ACT_DEQUEUE : (roll < 83) ? ACT_NORMAL :
                     (roll < 96) ? ACT_PRIORITY : ACT_UNUSED;
      default:
        req.action = (roll < 35) ? ACT_NORMAL : (roll < 68) ? ACT_PRIORITY :
                     (roll < 97) ? ACT_DEQUEUE : ACT_UNUSED;
    endcase
    if ($urandom_range(15) == 0) begin
      req.customer_id = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end
    return req;
  endfunction

  // Offers one request and holds it until the block accepts it. Idle cycles
  // are inserted before the offer unless steady is set. in_valid is left high
  // after acceptance, so back-to-back requests never lower and raise it in the
  // same time step. Signals are read straight after the edge, before any
  // register of the block has updated, so they hold their pre-edge values.
  task automatic issue(input in_req_t req, input logic pinned,
                       input out_rsp_t pinned_rsp);
    out_rsp_t model_rsp;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(posedge clk);
    end while (in_stall);
    // The model is always advanced; a hand-typed response only replaces what
    // it predicts for this one request.
    model_rsp = serve_request(req);
    awaited_rsp.push_back(pinned ? pinned_rsp : model_rsp);
  endtask

  // The receiving side stalls about a third of the time, except during the
  // steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Every accepted response is compared field by field with the oldest one
  // still owed. A response that nobody is waiting for is a failure too.
  always @(posedge clk) begin : check_rsp
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_rsp.size() == 0) begin
        flag_mismatch("response arrived with none outstanding");
      end else begin
        want = awaited_rsp.pop_front();
        compare_field("status", 16'(out_rsp.status), 16'(want.status));
        compare_field("ahead_count", 16'(out_rsp.ahead_count), 16'(want.ahead_count));
        compare_field("removed_id", out_rsp.removed_id, want.removed_id);
        compare_field("removed_priority", 16'(out_rsp.removed_priority),
                      16'(want.removed_priority));
        compare_field("remaining", 16'(out_rsp.remaining), 16'(want.remaining));
      end
    end
  end

  initial begin
    script_row_t row;
    in_req_t     req;
    mix_t        mix;
    int          idx;
    int          run_len;
    int          served;
    int          phase;
    int          spare;

    // Reset is held low from the start and released at a rising edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (idx = 0; idx < SCRIPT_LEN; idx++) begin
      row = SCRIPT[idx];
      issue(row.req, row.pinned, row.rsp);
    end

    // Random traffic in phases of one mix each. The fill phases are long
    // enough to drive a class to its depth, so full-class refusals and
    // empty-queue dequeues come up often. One phase runs with no idling on
    // either side, and every fifth phase boundary the sender waits until the
    // block has answered everything it was given.
    served = 0;
    phase  = 0;
    while (served < RANDOM_ITEMS) begin
      mix     = mix_t'($urandom_range(3));
      run_len = $urandom_range(80, 20);
      steady  = (phase == 3);
      if (steady) begin
        run_len = 200;
      end
      if (phase % 5 == 4) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0) begin
          @(posedge clk);
        end
      end
      repeat (run_len) begin
        req = pick_req(mix);
        issue(req, 1'b0, NO_RSP);
        // Requests with the unused code are not counted as traffic.
        if (req.action != ACT_UNUSED) begin
          served++;
        end
      end
      phase++;
    end
    steady = 1'b0;

    // Let the block answer what is still outstanding, then watch a little
    // longer for any response that should not come at all.
    in_valid <= 1'b0;
    @(posedge clk);
    spare = 0;
    while (awaited_rsp.size() != 0 && spare < DRAIN_LIMIT) begin
      @(posedge clk);
      spare++;
    end
    if (awaited_rsp.size() != 0) begin
      flag_mismatch($sformatf("%0d responses never arrived", awaited_rsp.size()));
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("tb_two_class_priority_queue_core OK");
    end else begin
      $display("tb_two_class_priority_queue_core NOT OK");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this time, even with
  // every idle and stall cycle the random draws can produce.
  initial begin
    #5ms;
    $display("tb_two_class_priority_queue_core NOT OK");
    $finish;
  end

endmodule
